### design/tlbpt_pkg.sv
// shared types and constants for the tlb and page table translation block
package tlbpt_pkg;

  localparam int DEF_TLB_ENTRIES   = 4;
  localparam int DEF_TABLE_ENTRIES = 16;

  localparam int PAGE_W   = 8;
  localparam int FRAME_W  = 8;
  localparam int LINE_W   = 5;
  localparam int STATUS_W = 3;
  localparam int SEED_W   = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_TLB_HIT   = 3'd0,
    ST_TABLE_HIT = 3'd1,
    ST_FAULT     = 3'd2,
    ST_LOADED    = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    KIND_LOAD      = 1'b0,
    KIND_TRANSLATE = 1'b1
  } kind_t;

  typedef struct packed {
    logic start;
    logic advance;
  } repl_ctl_t;

  typedef struct packed {
    logic done;
  } repl_stat_t;

endpackage

### design/tlbpt_repl.sv
// replacement lfsr and the tlb fill slot, taken by reciprocal multiplication
module tlbpt_repl
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = DEF_TLB_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         seed_we,
  input  logic [SEED_W-1:0]            seed,
  input  repl_ctl_t                    ctl,
  output repl_stat_t                   stat,
  output logic [((TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1)-1:0] slot
);

  localparam int IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int SHIFT   = SEED_W + $clog2(TLB_ENTRIES);
  localparam int RECIP_W = SEED_W + 1;
  localparam int PROD_W  = SEED_W + RECIP_W;
  localparam int RECIP   = ((1 << SHIFT) + TLB_ENTRIES - 1) / TLB_ENTRIES;

  logic [SEED_W-1:0] lfsr;
  logic [SEED_W-1:0] lfsr_next;
  logic [SEED_W-1:0] held;
  logic [PROD_W-1:0] prod;
  logic [SEED_W-1:0] quot;
  logic [SEED_W-1:0] quot_n;
  logic [IDX_W-1:0]  rem;
  logic              running;
  logic              done;

  assign lfsr_next = {lfsr[SEED_W-2:0], lfsr[15] ^ lfsr[13] ^ lfsr[12] ^ lfsr[10]};

  // quotient from the registered product, then the remainder
  assign quot   = SEED_W'(prod >> SHIFT);
  assign quot_n = quot * SEED_W'(TLB_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr    <= SEED_W'(1);
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (seed_we) begin
        lfsr <= (seed == '0) ? SEED_W'(1) : seed;
      end else if (ctl.advance) begin
        lfsr <= lfsr_next;
      end
      if (ctl.start) begin
        running <= 1'b1;
      end else if (running) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      held <= lfsr;
      prod <= PROD_W'(lfsr) * PROD_W'(RECIP);
    end
    if (running) begin
      rem <= IDX_W'(held - quot_n);
    end
  end

  assign stat.done = done;
  assign slot      = rem;

endmodule

### design/tlb_page_table_translate_top.sv
// top level: tlb in front of a page table, sequenced over one shared page comparator
//
//  channel   | handshake             | word
//  ----------+-----------------------+-----------------------------------------------
//  request   | start / busy          | kind, page_number, frame_number, line_offset
//  result    | done (one-cycle pulse) | status, physical_frame, physical_line
//  config    | random_seed_we        | random_seed
//
// load: the table is written in the load state. translate: a read state and a compare
// state per tlb entry probed; on a tlb miss, a read and a compare state per loaded table
// slot probed, and on a table hit the replacement slot (reciprocal multiply, then subtract)
// and a fill state. the result word follows in the cycle after the last busy cycle, with
// busy already low. probes run one at a time through the single page comparator and the
// one read port of each table. reset clears all valid state. the receiver cannot stall: done is a pulse.
module tlb_page_table_translate_top
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES   = DEF_TLB_ENTRIES,
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                kind,
  input  logic [PAGE_W-1:0]   page_number,
  input  logic [FRAME_W-1:0]  frame_number,
  input  logic [LINE_W-1:0]   line_offset,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [FRAME_W-1:0]  physical_frame,
  output logic [LINE_W-1:0]   physical_line,
  input  logic                random_seed_we,
  input  logic [SEED_W-1:0]   random_seed
);

  localparam int TLB_IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int TAB_IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_W   = PAGE_W + FRAME_W;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b00000001,
    S_LOAD    = 8'b00000010,
    S_TLB_RD  = 8'b00000100,
    S_TLB_CMP = 8'b00001000,
    S_TAB_RD  = 8'b00010000,
    S_TAB_CMP = 8'b00100000,
    S_MOD     = 8'b01000000,
    S_FILL    = 8'b10000000
  } state_t;

  state_t                 state;
  logic [TLB_IDX_W-1:0]   tlb_idx;
  logic [TAB_IDX_W-1:0]   tab_idx;
  logic [CNT_W-1:0]       fill_count;
  logic [TLB_ENTRIES-1:0] tlb_valid;

  logic                   req_kind;
  logic [PAGE_W-1:0]      req_page;
  logic [FRAME_W-1:0]     req_frame;
  logic [LINE_W-1:0]      req_line;
  logic [FRAME_W-1:0]     hit_frame;

  status_t                status_r;
  logic [FRAME_W-1:0]     frame_r;
  logic [LINE_W-1:0]      line_r;
  logic                   done_r;

  logic [ENTRY_W-1:0]     tlb_mem [TLB_ENTRIES];
  logic [ENTRY_W-1:0]     tab_mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0]     tlb_rd;
  logic [ENTRY_W-1:0]     tab_rd;

  logic                   table_full;
  logic                   tab_we;
  logic                   tlb_we;
  logic [PAGE_W-1:0]      cmp_page;
  logic                   page_match;
  logic                   tlb_last;
  logic                   tab_last;

  repl_ctl_t              repl_ctl;
  repl_stat_t             repl_stat;
  logic [TLB_IDX_W-1:0]   repl_slot;

  assign busy       = (state != S_IDLE);
  assign table_full = (fill_count == CNT_W'(TABLE_ENTRIES));
  assign tab_we     = (state == S_LOAD) && !table_full;
  assign tlb_we     = (state == S_FILL);
  assign tlb_last   = (tlb_idx == TLB_IDX_W'(TLB_ENTRIES - 1));
  assign tab_last   = ((CNT_W'(tab_idx) + CNT_W'(1)) == fill_count);

  // shared page comparator
  assign cmp_page   = (state == S_TLB_CMP) ? tlb_rd[ENTRY_W-1:FRAME_W]
                                           : tab_rd[ENTRY_W-1:FRAME_W];
  assign page_match = (cmp_page == req_page);

  assign repl_ctl.start   = (state == S_TAB_CMP) && page_match;
  assign repl_ctl.advance = tlb_we;

  tlbpt_repl #(
    .TLB_ENTRIES(TLB_ENTRIES)
  ) u_repl (
    .clk     (clk),
    .rst     (rst),
    .seed_we (random_seed_we),
    .seed    (random_seed),
    .ctl     (repl_ctl),
    .stat    (repl_stat),
    .slot    (repl_slot)
  );

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[fill_count[TAB_IDX_W-1:0]] <= {req_page, req_frame};
    end
    tab_rd <= tab_mem[tab_idx];
  end

  always_ff @(posedge clk) begin
    if (tlb_we) begin
      tlb_mem[repl_slot] <= {req_page, hit_frame};
    end
    tlb_rd <= tlb_mem[tlb_idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_kind  <= kind;
      req_page  <= page_number;
      req_frame <= frame_number;
      req_line  <= line_offset;
    end
    if (repl_ctl.start) begin
      hit_frame <= tab_rd[FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tlb_idx    <= '0;
      tab_idx    <= '0;
      fill_count <= '0;
      tlb_valid  <= '0;
      done_r     <= 1'b0;
      status_r   <= ST_TLB_HIT;
      frame_r    <= '0;
      line_r     <= '0;
    end else begin
      done_r <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            tlb_idx <= '0;
            tab_idx <= '0;
            state   <= (kind == KIND_TRANSLATE) ? S_TLB_RD : S_LOAD;
          end
        end
        S_LOAD: begin
          if (table_full) begin
            status_r <= ST_FULL;
          end else begin
            status_r   <= ST_LOADED;
            fill_count <= fill_count + CNT_W'(1);
          end
          frame_r <= '0;
          line_r  <= req_line;
          done_r  <= 1'b1;
          state   <= S_IDLE;
        end
        S_TLB_RD: begin
          state <= S_TLB_CMP;
        end
        S_TLB_CMP: begin
          if (tlb_valid[tlb_idx] && page_match) begin
            status_r <= ST_TLB_HIT;
            frame_r  <= tlb_rd[FRAME_W-1:0];
            line_r   <= req_line;
            done_r   <= 1'b1;
            state    <= S_IDLE;
          end else if (!tlb_last) begin
            tlb_idx <= tlb_idx + TLB_IDX_W'(1);
            state   <= S_TLB_RD;
          end else if (fill_count == '0) begin
            status_r <= ST_FAULT;
            frame_r  <= '0;
            line_r   <= req_line;
            done_r   <= 1'b1;
            state    <= S_IDLE;
          end else begin
            state <= S_TAB_RD;
          end
        end
        S_TAB_RD: begin
          state <= S_TAB_CMP;
        end
        S_TAB_CMP: begin
          if (page_match) begin
            state <= S_MOD;
          end else if (!tab_last) begin
            tab_idx <= tab_idx + TAB_IDX_W'(1);
            state   <= S_TAB_RD;
          end else begin
            status_r <= ST_FAULT;
            frame_r  <= '0;
            line_r   <= req_line;
            done_r   <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_MOD: begin
          if (repl_stat.done) begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          tlb_valid[repl_slot] <= 1'b1;
          status_r <= ST_TABLE_HIT;
          frame_r  <= hit_frame;
          line_r   <= req_line;
          done_r   <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign done           = done_r;
  assign status         = status_r;
  assign physical_frame = frame_r;
  assign physical_line  = line_r;

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(state == S_IDLE))
    else $error("result word without work behind it");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count past table depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status_r == ST_FULL) |-> table_full)
    else $error("table full reported with free slots");

  a_fill_after_mod: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> ($past(state == S_MOD) && $past(repl_stat.done)))
    else $error("tlb fill without a finished replacement slot");

  a_kind_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_TLB_RD || state == S_TAB_RD) |-> (req_kind == KIND_TRANSLATE))
    else $error("lookup running for a load word");

endmodule
